>>> rtl/text_console_cell_writer_assert.svh
// Assertion macros for the text console cell writer.
// Used by the top level; expands to nothing when SYNTHESIS is defined.
`ifndef TEXT_CONSOLE_CELL_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CELL_WRITER_ASSERT_SVH
`ifndef SYNTHESIS
`define TCCW_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TCCW_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TCCW_ASSERT_NOW(lbl, ante, cons)
`define TCCW_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> rtl/tccw_pkg.sv
// Shared types and constants of the text console cell writer.
// No dependencies; used by every module of the block.
package tccw_pkg;

    localparam int CHAR_W  = 8;
    localparam int IDX_W   = 11;
    localparam int VAL_W   = 16;
    localparam int X_W     = 7;
    localparam int Y_W     = 5;
    localparam int POS_W   = 11;
    localparam int COLOR_W = 4;

    localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic CFG_FG = 1'b0;
    localparam logic CFG_BG = 1'b1;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;
    localparam int Q_CNT_W = 2;

    typedef enum logic [2:0] {
        KIND_PUT  = 3'd0,
        KIND_LF   = 3'd1,
        KIND_CR   = 3'd2,
        KIND_BS   = 3'd3,
        KIND_READ = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [CHAR_W-1:0]  char_code;
        logic [IDX_W-1:0]   read_index;
        logic               last;
    } t_cmd;

endpackage

>>> rtl/tccw_queue.sv
// Two-entry command queue between the front and back parts.
// Depends on tccw_pkg for the command type and depth constants.
module tccw_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tccw_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output tccw_pkg::t_cmd  o_cmd
);

    tccw_pkg::t_cmd                    r_slot [tccw_pkg::Q_DEPTH];
    logic [tccw_pkg::Q_AW-1:0]         r_wptr, n_wptr;
    logic [tccw_pkg::Q_AW-1:0]         r_rptr, n_rptr;
    logic [tccw_pkg::Q_CNT_W-1:0]      r_count, n_count;
    logic                              w_do_push, w_do_pop;

    assign o_full    = (r_count == tccw_pkg::Q_CNT_W'(tccw_pkg::Q_DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_cmd     = r_slot[r_rptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr  = w_do_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = w_do_pop ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count;
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

endmodule

>>> rtl/tccw_front.sv
// Front part: takes input requests and sorts them into command kinds.
// Depends on tccw_pkg for the command type and character codes.
module tccw_front (
    input  logic                          i_in_valid,
    input  logic                          i_opcode,
    input  logic [tccw_pkg::CHAR_W-1:0]   i_char_code,
    input  logic [tccw_pkg::IDX_W-1:0]    i_read_index,
    input  logic                          i_last_of_string,
    input  logic                          i_q_full,
    input  logic                          i_hold,
    output logic                          o_in_stall,
    output logic                          o_push,
    output tccw_pkg::t_cmd                o_cmd
);

    tccw_pkg::t_kind w_kind;

    always_comb begin
        priority if (i_opcode == tccw_pkg::OP_READ) begin
            w_kind = tccw_pkg::KIND_READ;
        end else if (i_char_code == tccw_pkg::CH_LF) begin
            w_kind = tccw_pkg::KIND_LF;
        end else if (i_char_code == tccw_pkg::CH_CR) begin
            w_kind = tccw_pkg::KIND_CR;
        end else if (i_char_code == tccw_pkg::CH_BS) begin
            w_kind = tccw_pkg::KIND_BS;
        end else begin
            w_kind = tccw_pkg::KIND_PUT;
        end
    end

    // hold off requests while the queue is full or the store is being cleared
    assign o_in_stall = i_q_full || i_hold;
    assign o_push     = i_in_valid && !o_in_stall;

    assign o_cmd.kind       = w_kind;
    assign o_cmd.char_code  = i_char_code;
    assign o_cmd.read_index = i_read_index;
    assign o_cmd.last       = i_last_of_string;

endmodule

>>> rtl/tccw_back.sv
// Back part: cursor, cell store with rotating top row, scroll fill and result register.
// Depends on tccw_pkg for the command type, field widths and character codes.
module tccw_back #(
    parameter int WIDTH  = 80,
    parameter int HEIGHT = 25
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cmd_valid,
    input  tccw_pkg::t_cmd                 i_cmd,
    output logic                           o_pop,
    input  logic [tccw_pkg::COLOR_W-1:0]   i_fg,
    input  logic [tccw_pkg::COLOR_W-1:0]   i_bg,
    output logic                           o_clearing,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [tccw_pkg::VAL_W-1:0]     o_cell_value,
    output logic [tccw_pkg::X_W-1:0]       o_cursor_x,
    output logic [tccw_pkg::Y_W-1:0]       o_cursor_y,
    output logic [tccw_pkg::POS_W-1:0]     o_cursor_pos,
    output logic                           o_cursor_update,
    output logic                           o_scrolled
);

    localparam int CELLS = WIDTH * HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int COL_W = $clog2(WIDTH);
    localparam int ROW_W = $clog2(HEIGHT);
    localparam int IW    = tccw_pkg::IDX_W;
    localparam int RW    = (AW > IW) ? AW : IW;
    localparam int XW    = tccw_pkg::X_W;
    localparam int YW    = tccw_pkg::Y_W;
    localparam int PW    = tccw_pkg::POS_W;
    localparam int VW    = tccw_pkg::VAL_W;

    localparam logic [AW:0]      CELLS_X   = (AW+1)'(CELLS);
    localparam logic [AW:0]      WIDTH_X   = (AW+1)'(WIDTH);
    localparam logic [AW-1:0]    LAST_CELL = AW'(CELLS - 1);
    localparam logic [AW-1:0]    LAST_ROWP = AW'((HEIGHT - 1) * WIDTH);
    localparam logic [AW-1:0]    WIDTH_A   = AW'(WIDTH);
    localparam logic [AW-1:0]    WIDTH_M1A = AW'(WIDTH - 1);
    localparam logic [COL_W-1:0] LAST_COL  = COL_W'(WIDTH - 1);
    localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(HEIGHT - 1);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_FILL  = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [AW-1:0]     r_pos, n_pos;
    logic [AW-1:0]     r_base, n_base;
    logic [AW-1:0]     r_cnt, n_cnt;
    logic              r_hit, n_hit;
    logic              r_update, n_update;
    logic              r_scr, n_scr;

    logic              r_out_valid, n_out_valid;
    logic [VW-1:0]     r_cell;
    logic [XW-1:0]     r_x;
    logic [YW-1:0]     r_y;
    logic [PW-1:0]     r_p;
    logic              r_upd_o;
    logic              r_scr_o;

    logic [VW-1:0]     r_mem [CELLS];
    logic [VW-1:0]     r_rd_data;

    logic [7:0]        w_attr;
    logic [VW-1:0]     w_blank;
    logic              w_in_range;
    logic [AW-1:0]     w_lin;
    logic [AW:0]       w_sum;
    logic [AW-1:0]     w_phys;
    logic [AW:0]       w_base_nx;
    logic [AW-1:0]     w_pos_lf;
    logic              w_load;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [VW-1:0]     w_wdata;
    logic              w_rd_en;

    assign w_attr     = {i_bg, i_fg};
    assign w_blank    = {w_attr, tccw_pkg::CH_SPACE};
    assign w_in_range = (RW'(i_cmd.read_index) < RW'(CELLS));
    assign o_pop      = (r_state == ST_IDLE) && i_cmd_valid;
    assign o_clearing = (r_state == ST_CLEAR);
    assign w_load     = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);

    // logical cell index of the access, then rotate by the top-row base
    always_comb begin
        unique case (i_cmd.kind)
            tccw_pkg::KIND_READ: w_lin = AW'(i_cmd.read_index);
            tccw_pkg::KIND_BS:   w_lin = r_pos - 1'b1;
            default:             w_lin = r_pos;
        endcase
    end

    assign w_sum     = {1'b0, w_lin} + {1'b0, r_base};
    assign w_phys    = (w_sum >= CELLS_X) ? AW'(w_sum - CELLS_X) : w_sum[AW-1:0];
    assign w_base_nx = {1'b0, r_base} + WIDTH_X;
    assign w_pos_lf  = r_pos - AW'(r_col) + WIDTH_A;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_phys;
        w_wdata = w_blank;
        w_rd_en = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_cnt;
                w_wdata = '0;
            end
            ST_FILL: begin
                w_we    = 1'b1;
                w_waddr = r_base + r_cnt;
            end
            ST_IDLE: begin
                if (o_pop) begin
                    unique case (i_cmd.kind)
                        tccw_pkg::KIND_PUT: begin
                            w_we    = 1'b1;
                            w_wdata = {w_attr, i_cmd.char_code};
                        end
                        tccw_pkg::KIND_BS:   w_we    = (r_col != '0);
                        tccw_pkg::KIND_READ: w_rd_en = w_in_range;
                        default:             w_we    = 1'b0;
                    endcase
                end
            end
            default: w_we = 1'b0;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_col    = r_col;
        n_row    = r_row;
        n_pos    = r_pos;
        n_base   = r_base;
        n_cnt    = r_cnt;
        n_hit    = r_hit;
        n_update = r_update;
        n_scr    = r_scr;
        unique case (r_state)
            ST_CLEAR: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_CELL) begin
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (o_pop) begin
                    n_hit    = (i_cmd.kind == tccw_pkg::KIND_READ) && w_in_range;
                    n_update = (i_cmd.kind != tccw_pkg::KIND_READ) && i_cmd.last;
                    n_scr    = 1'b0;
                    n_state  = ST_DONE;
                    unique case (i_cmd.kind)
                        tccw_pkg::KIND_CR: begin
                            n_col = '0;
                            n_pos = r_pos - AW'(r_col);
                        end
                        tccw_pkg::KIND_BS: begin
                            if (r_col != '0) begin
                                n_col = r_col - 1'b1;
                                n_pos = r_pos - 1'b1;
                            end
                        end
                        tccw_pkg::KIND_PUT, tccw_pkg::KIND_LF: begin
                            if (i_cmd.kind == tccw_pkg::KIND_PUT && r_col != LAST_COL) begin
                                n_col = r_col + 1'b1;
                                n_pos = r_pos + 1'b1;
                            end else if (r_row == LAST_ROW) begin
                                // scroll: blank the old top row, which becomes the bottom
                                n_col   = '0;
                                n_pos   = LAST_ROWP;
                                n_cnt   = '0;
                                n_scr   = 1'b1;
                                n_state = ST_FILL;
                            end else begin
                                n_col = '0;
                                n_row = r_row + 1'b1;
                                n_pos = w_pos_lf;
                            end
                        end
                        default: n_col = r_col;
                    endcase
                end
            end
            ST_FILL: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == WIDTH_M1A) begin
                    n_cnt   = '0;
                    n_base  = (w_base_nx == CELLS_X) ? '0 : w_base_nx[AW-1:0];
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign n_out_valid = w_load || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_col       <= '0;
            r_row       <= '0;
            r_pos       <= '0;
            r_base      <= '0;
            r_cnt       <= '0;
            r_hit       <= 1'b0;
            r_update    <= 1'b0;
            r_scr       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_pos       <= n_pos;
            r_base      <= n_base;
            r_cnt       <= n_cnt;
            r_hit       <= n_hit;
            r_update    <= n_update;
            r_scr       <= n_scr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cell  <= r_hit ? r_rd_data : '0;
            r_x     <= XW'(r_col);
            r_y     <= YW'(r_row);
            r_p     <= PW'(r_pos);
            r_upd_o <= r_update;
            r_scr_o <= r_scr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_phys];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_cell_value    = r_cell;
    assign o_cursor_x      = r_x;
    assign o_cursor_y      = r_y;
    assign o_cursor_pos    = r_p;
    assign o_cursor_update = r_upd_o;
    assign o_scrolled      = r_scr_o;

endmodule

>>> rtl/text_console_cell_writer.sv
// Text console cell writer: cursor and WIDTH x HEIGHT cell store fed one character per request.
// The result register loads after the back part's execute step; a scroll puts a fill step that blanks a row between.
// The back part takes a new request only once its execute step and result load step are done, and
// it holds in the result load step while the output is stalled; the queue takes requests meanwhile.
// Reset: clearing pass writes zero to all WIDTH*HEIGHT cells, one per cycle, input stalled.
// Colors reset to fg 7, bg 0; configuration writes are taken at any time, even while clearing.
`include "text_console_cell_writer_assert.svh"
module text_console_cell_writer #(
    parameter int WIDTH  = 80,
    parameter int HEIGHT = 25
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_opcode,
    input  logic [tccw_pkg::CHAR_W-1:0]    i_char_code,
    input  logic [tccw_pkg::IDX_W-1:0]     i_read_index,
    input  logic                           i_last_of_string,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [tccw_pkg::VAL_W-1:0]     o_cell_value,
    output logic [tccw_pkg::X_W-1:0]       o_cursor_x,
    output logic [tccw_pkg::Y_W-1:0]       o_cursor_y,
    output logic [tccw_pkg::POS_W-1:0]     o_cursor_pos,
    output logic                           o_cursor_update,
    output logic                           o_scrolled,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_index,
    input  logic [tccw_pkg::COLOR_W-1:0]   i_cfg_data
);

    logic [tccw_pkg::COLOR_W-1:0] r_fg;
    logic [tccw_pkg::COLOR_W-1:0] r_bg;

    logic            w_push;
    logic            w_q_full;
    logic            w_q_valid;
    logic            w_pop;
    logic            w_clearing;
    tccw_pkg::t_cmd  w_front_cmd;
    tccw_pkg::t_cmd  w_back_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= 4'd7;
            r_bg <= 4'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                tccw_pkg::CFG_FG: r_fg <= i_cfg_data;
                tccw_pkg::CFG_BG: r_bg <= i_cfg_data;
                default:          r_fg <= r_fg;
            endcase
        end
    end

    tccw_front u_front (
        .i_in_valid       (i_in_valid),
        .i_opcode         (i_opcode),
        .i_char_code      (i_char_code),
        .i_read_index     (i_read_index),
        .i_last_of_string (i_last_of_string),
        .i_q_full         (w_q_full),
        .i_hold           (w_clearing),
        .o_in_stall       (o_in_stall),
        .o_push           (w_push),
        .o_cmd            (w_front_cmd)
    );

    tccw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_back_cmd)
    );

    tccw_back #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (w_q_valid),
        .i_cmd           (w_back_cmd),
        .o_pop           (w_pop),
        .i_fg            (r_fg),
        .i_bg            (r_bg),
        .o_clearing      (w_clearing),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_cell_value    (o_cell_value),
        .o_cursor_x      (o_cursor_x),
        .o_cursor_y      (o_cursor_y),
        .o_cursor_pos    (o_cursor_pos),
        .o_cursor_update (o_cursor_update),
        .o_scrolled      (o_scrolled)
    );

    `TCCW_ASSERT_NOW(a_no_result_while_clearing, w_clearing, !o_out_valid && o_in_stall)
    `TCCW_ASSERT_NOW(a_scroll_on_last_row, o_out_valid && o_scrolled, o_cursor_y == 5'(HEIGHT - 1))
    `TCCW_ASSERT_NOW(a_update_has_no_cell, o_out_valid && o_cursor_update, o_cell_value == '0)
    `TCCW_ASSERT_NXT(a_cfg_fg_taken, i_cfg_valid && o_cfg_ready && i_cfg_index == tccw_pkg::CFG_FG, r_fg == $past(i_cfg_data))

endmodule

>>> dv/text_console_cell_writer_test.sv
// Self-checking bench for text_console_cell_writer: a screen mirror predicts every result.
// Depends on tccw_pkg and the text_console_cell_writer RTL; drives requests at random and writes colors per phase.
module text_console_cell_writer_test;

    localparam int WIDTH      = 80;
    localparam int HEIGHT     = 25;
    localparam int CELL_COUNT = WIDTH * HEIGHT;
    localparam int PHASES     = 6;
    localparam int PHASE_REQS = 258;
    localparam int HOLD_AT    = 500;
    localparam int HOLD_LEN   = 400;

    typedef struct packed {
        logic [tccw_pkg::VAL_W-1:0] value;
        logic [tccw_pkg::X_W-1:0]   x;
        logic [tccw_pkg::Y_W-1:0]   y;
        logic [tccw_pkg::POS_W-1:0] pos;
        logic                       upd;
        logic                       scr;
    } t_console_result;

    class screen_mirror;
        logic [tccw_pkg::VAL_W-1:0]   cells [CELL_COUNT];
        int unsigned                  col;
        int unsigned                  line;
        logic [tccw_pkg::COLOR_W-1:0] fg;
        logic [tccw_pkg::COLOR_W-1:0] bg;
        t_console_result              awaited[$];
        int                           fails;
        int                           checked;
        int                           reads;
        int                           writes;
        int                           scrolls;
        int                           wraps;
        int                           far_reads;
        int                           color_writes;

        function new();
            foreach (cells[i]) cells[i] = '0;
            col = 0;
            line = 0;
            fg = 4'd7;
            bg = 4'd0;
        endfunction

        function void set_color(logic idx, logic [tccw_pkg::COLOR_W-1:0] v);
            if (idx == tccw_pkg::CFG_FG) fg = v;
            else bg = v;
            color_writes++;
        endfunction

        function logic [tccw_pkg::VAL_W-1:0] paint(logic [tccw_pkg::CHAR_W-1:0] ch);
            return {bg, fg, ch};
        endfunction

        function bit feed_line();
            col = 0;
            line++;
            if (line < HEIGHT) return 1'b0;
            // shift rows up and blank the new bottom row
            for (int i = 0; i < WIDTH * (HEIGHT - 1); i++) cells[i] = cells[i + WIDTH];
            for (int i = 0; i < WIDTH; i++)
                cells[WIDTH * (HEIGHT - 1) + i] = paint(tccw_pkg::CH_SPACE);
            line = HEIGHT - 1;
            scrolls++;
            return 1'b1;
        endfunction

        function void take_request(logic op, logic [tccw_pkg::CHAR_W-1:0] ch,
                                   logic [tccw_pkg::IDX_W-1:0] idx, logic last);
            t_console_result r;
            int unsigned     p;
            r = '0;
            if (op == tccw_pkg::OP_READ) begin
                reads++;
                if (idx < CELL_COUNT) r.value = cells[idx];
                else far_reads++;
            end else begin
                writes++;
                case (ch)
                    tccw_pkg::CH_LF: r.scr = feed_line();
                    tccw_pkg::CH_CR: col = 0;
                    tccw_pkg::CH_BS: begin
                        if (col != 0) begin
                            col--;
                            cells[line * WIDTH + col] = paint(tccw_pkg::CH_SPACE);
                        end
                    end
                    default: begin
                        cells[line * WIDTH + col] = paint(ch);
                        col++;
                        if (col >= WIDTH) begin
                            wraps++;
                            r.scr = feed_line();
                        end
                    end
                endcase
                r.upd = last;
            end
            p = line * WIDTH + col;
            r.x = col[tccw_pkg::X_W-1:0];
            r.y = line[tccw_pkg::Y_W-1:0];
            r.pos = p[tccw_pkg::POS_W-1:0];
            awaited.push_back(r);
        endfunction

        function void compare(string field, int unsigned e, int unsigned a);
            if (e != a) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, e, a);
                fails++;
            end
        endfunction

        function void match_result(t_console_result a);
            t_console_result e;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, a);
                fails++;
                return;
            end
            e = awaited.pop_front();
            checked++;
            compare("cell_value", 32'(e.value), 32'(a.value));
            compare("cursor_x", 32'(e.x), 32'(a.x));
            compare("cursor_y", 32'(e.y), 32'(a.y));
            compare("cursor_pos", 32'(e.pos), 32'(a.pos));
            compare("cursor_update", 32'(e.upd), 32'(a.upd));
            compare("scrolled", 32'(e.scr), 32'(a.scr));
        endfunction
    endclass

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic                         in_op = tccw_pkg::OP_WRITE;
    logic [tccw_pkg::CHAR_W-1:0]  in_char = '0;
    logic [tccw_pkg::IDX_W-1:0]   in_index = '0;
    logic                         in_last = 1'b0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [tccw_pkg::VAL_W-1:0]   res_value;
    logic [tccw_pkg::X_W-1:0]     res_x;
    logic [tccw_pkg::Y_W-1:0]     res_y;
    logic [tccw_pkg::POS_W-1:0]   res_pos;
    logic                         res_upd;
    logic                         res_scr;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic                         cfg_index = tccw_pkg::CFG_FG;
    logic [tccw_pkg::COLOR_W-1:0] cfg_data = '0;

    bit          calm = 1'b0;
    bit          long_lines = 1'b0;
    bit          held_once = 1'b0;
    int unsigned hold_left = 0;
    screen_mirror mirror = new();

    text_console_cell_writer #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_opcode         (in_op),
        .i_char_code      (in_char),
        .i_read_index     (in_index),
        .i_last_of_string (in_last),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_cell_value     (res_value),
        .o_cursor_x       (res_x),
        .o_cursor_y       (res_y),
        .o_cursor_pos     (res_pos),
        .o_cursor_update  (res_upd),
        .o_scrolled       (res_scr),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    always #10 clk = ~clk;

    initial begin
        #40_000_000;
        $display("text_console_cell_writer_test failed");
        $finish;
    end

    // Result side: check accepted results, stall at random, one long hold-off.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall)
                mirror.match_result({res_value, res_x, res_y, res_pos, res_upd, res_scr});
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end else if (!held_once && mirror.checked == HOLD_AT) begin
                held_once <= 1'b1;
                hold_left <= HOLD_LEN;
                out_stall <= 1'b1;
            end else begin
                out_stall <= !calm && ($urandom_range(99) < 13);
            end
        end
    end

    task automatic send_request(logic op, logic [tccw_pkg::CHAR_W-1:0] ch,
                                logic [tccw_pkg::IDX_W-1:0] idx, logic last);
        while (!calm && $urandom_range(99) < 13) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_op <= op;
        in_char <= ch;
        in_index <= idx;
        in_last <= last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        mirror.take_request(op, ch, idx, last);
    endtask

    task automatic send_random_request();
        int unsigned                 r;
        logic [tccw_pkg::CHAR_W-1:0] ch;
        logic [tccw_pkg::IDX_W-1:0]  idx;
        r = $urandom_range(99);
        ch = tccw_pkg::CHAR_W'($urandom_range(255));
        idx = ($urandom_range(19) == 0)
            ? tccw_pkg::IDX_W'($urandom_range(2047, CELL_COUNT))
            : tccw_pkg::IDX_W'($urandom_range(CELL_COUNT - 1));
        if (r < 22) begin
            send_request(tccw_pkg::OP_READ, ch, idx, 1'($urandom_range(1)));
        end else begin
            r = $urandom_range(99);
            // long lines let rows fill and wrap; dense text scrolls often
            if (long_lines) begin
                if (r < 2) ch = tccw_pkg::CH_LF;
                else if (r < 3) ch = tccw_pkg::CH_CR;
                else if (r < 8) ch = tccw_pkg::CH_BS;
            end else begin
                if (r < 15) ch = tccw_pkg::CH_LF;
                else if (r < 22) ch = tccw_pkg::CH_CR;
                else if (r < 32) ch = tccw_pkg::CH_BS;
            end
            send_request(tccw_pkg::OP_WRITE, ch, idx, $urandom_range(3) == 0);
        end
    endtask

    task automatic write_color(logic idx, logic [tccw_pkg::COLOR_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        mirror.set_color(idx, v);
        @(posedge clk);
    endtask

    // Drop the request, let every result come back, then give the block time to settle.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (mirror.awaited.size() != 0) @(posedge clk);
        repeat (WIDTH + 8) @(posedge clk);
    endtask

    initial begin
        logic [tccw_pkg::COLOR_W-1:0] f;
        logic [tccw_pkg::COLOR_W-1:0] b;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset contents and colors, store edges, control characters
        send_request(tccw_pkg::OP_READ, 8'hFF, 11'd0, 1'b0);
        send_request(tccw_pkg::OP_READ, 8'h00, tccw_pkg::IDX_W'(CELL_COUNT - 1), 1'b1);
        send_request(tccw_pkg::OP_READ, 8'hA5, tccw_pkg::IDX_W'(CELL_COUNT), 1'b0);
        send_request(tccw_pkg::OP_READ, 8'h5A, 11'h7FF, 1'b1);
        send_request(tccw_pkg::OP_WRITE, tccw_pkg::CH_BS, 11'h7FF, 1'b1);
        send_request(tccw_pkg::OP_WRITE, 8'h41, 11'd0, 1'b1);
        send_request(tccw_pkg::OP_WRITE, 8'h00, 11'h400, 1'b0);
        send_request(tccw_pkg::OP_WRITE, 8'hFF, 11'h3FF, 1'b0);
        send_request(tccw_pkg::OP_WRITE, tccw_pkg::CH_BS, 11'd5, 1'b1);
        send_request(tccw_pkg::OP_READ, 8'h00, 11'd2, 1'b0);
        send_request(tccw_pkg::OP_READ, 8'h00, 11'd1, 1'b1);
        send_request(tccw_pkg::OP_WRITE, tccw_pkg::CH_CR, 11'd0, 1'b1);
        send_request(tccw_pkg::OP_READ, 8'h00, 11'd0, 1'b1);
        send_request(tccw_pkg::OP_WRITE, tccw_pkg::CH_LF, 11'h555, 1'b0);
        send_request(tccw_pkg::OP_WRITE, 8'h7E, 11'h2AA, 1'b0);
        send_request(tccw_pkg::OP_WRITE, tccw_pkg::CH_BS, 11'd0, 1'b0);
        send_request(tccw_pkg::OP_WRITE, tccw_pkg::CH_BS, 11'd0, 1'b1);
        send_request(tccw_pkg::OP_READ, 8'h00, tccw_pkg::IDX_W'(WIDTH), 1'b0);
        send_request(tccw_pkg::OP_WRITE, 8'h80, 11'd0, 1'b1);
        send_request(tccw_pkg::OP_READ, 8'h00, 11'd1024, 1'b0);
        drain();

        for (int ph = 1; ph <= PHASES; ph++) begin
            case (ph)
                1: begin f = 4'd0;  b = 4'd0;  end
                2: begin f = 4'd15; b = 4'd15; end
                4: begin f = 4'd15; b = 4'd0;  end
                5: begin f = 4'd0;  b = 4'd15; end
                default: begin
                    f = tccw_pkg::COLOR_W'($urandom_range(15));
                    b = tccw_pkg::COLOR_W'($urandom_range(15));
                end
            endcase
            write_color(tccw_pkg::CFG_FG, f);
            write_color(tccw_pkg::CFG_BG, b);
            calm = (ph == 3);
            long_lines = ph[0];
            for (int k = 0; k < PHASE_REQS; k++) send_random_request();
            drain();
        end

        $display("covered %0d writes and %0d reads (%0d out of range), %0d wraps, %0d scrolls",
                 mirror.writes, mirror.reads, mirror.far_reads, mirror.wraps, mirror.scrolls);
        $display("%0d color writes, %0d results checked, %0d mismatches",
                 mirror.color_writes, mirror.checked, mirror.fails);
        if (mirror.fails == 0 && mirror.awaited.size() == 0) begin
            $display("text_console_cell_writer_test passed");
        end else begin
            $display("text_console_cell_writer_test failed");
        end
        $finish;
    end
endmodule
